// ===== sv/pairwise_kernel_density_sum_macros.svh =====
// Assertion macros for the pairwise kernel density sum block.
`ifndef PAIRWISE_KERNEL_DENSITY_SUM_MACROS_SVH
`define PAIRWISE_KERNEL_DENSITY_SUM_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define PKDS_ASSERT_IMP(lbl, ck, rn, a, b, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) else $error(msg);
// next-cycle implication, disabled in reset
`define PKDS_ASSERT_NXT(lbl, ck, rn, a, b, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) else $error(msg);
`else
`define PKDS_ASSERT_IMP(lbl, ck, rn, a, b, msg)
`define PKDS_ASSERT_NXT(lbl, ck, rn, a, b, msg)
`endif
`endif

// ===== sv/pkds_pkg.sv =====
// Shared types, widths and codes of the pairwise kernel density sum block.
`default_nettype none
package pkds_pkg;
    localparam int COORD_W    = 18;
    localparam int VALUE_W    = 32;
    localparam int KWORD_W    = 18;
    localparam int SLOT_W     = 10;
    localparam int SUM_W      = 48;
    localparam int RADIUS_W   = 17;
    localparam int MULT_W     = 32;
    localparam int INVW_W     = 17;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int ACTION_W   = 2;

    // scaled coordinate path
    localparam int CPROD_W = COORD_W + INVW_W + 1;
    localparam int SC_W    = CPROD_W - 16;
    localparam int ABS_W   = SC_W;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int DSQ_W   = SQ_W + 2;
    localparam int HL_W    = DSQ_W + 16;
    localparam int IDXRAW_W = HL_W + 1 - 32;
    localparam int KPROD_W = KWORD_W + VALUE_W;
    localparam int PT_W    = 3 * COORD_W + VALUE_W;

    localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVW   = 2'd2;

    localparam logic [INVW_W-1:0] INVW_RESET = 17'd65536;

    typedef struct packed {
        logic mult;
        logic hold;
        logic eval;
        logic square;
    } cell_ctl_t;

    typedef struct packed {
        logic             in_box;
        logic [DSQ_W-1:0] dsq;
    } chain_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]   acc,
        input logic signed [KPROD_W-1:0] prod
    );
        logic signed [KPROD_W:0] s;
        logic signed [KPROD_W:0] hi;
        logic signed [KPROD_W:0] lo;
        s  = (KPROD_W+1)'(acc) + (KPROD_W+1)'(prod);
        hi = (KPROD_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
        lo = (KPROD_W+1)'($signed({1'b1, {(SUM_W-1){1'b0}}}));
        if (s > hi)
            return {1'b0, {(SUM_W-1){1'b1}}};
        else if (s < lo)
            return {1'b1, {(SUM_W-1){1'b0}}};
        else
            return s[SUM_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== sv/pkds_in_if.sv =====
// Request channel: command, point data, kernel word and slot.
`default_nettype none
interface pkds_in_if;
    import pkds_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic signed [VALUE_W-1:0]  sample_value;
    logic signed [KWORD_W-1:0]  kernel_word;
    logic [SLOT_W-1:0]          slot_index;

    modport source (output valid, action, coord_x, coord_y, coord_z, sample_value,
                    kernel_word, slot_index, input ready);
    modport sink   (input valid, action, coord_x, coord_y, coord_z, sample_value,
                    kernel_word, slot_index, output ready);
endinterface
`default_nettype wire

// ===== sv/pkds_out_if.sv =====
// Result channel: density sum, point number and compute flag.
`default_nettype none
interface pkds_out_if;
    import pkds_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SUM_W-1:0]   density_sum;
    logic [SLOT_W-1:0]         point_number;
    logic                      compute_done;

    modport source (output valid, density_sum, point_number, compute_done, input ready);
    modport sink   (input valid, density_sum, point_number, compute_done, output ready);
endinterface
`default_nettype wire

// ===== sv/pkds_axis_cell.sv =====
// One axis cell: scales a coordinate, forms |d|, box test and square, adds to chain.
`default_nettype none
module pkds_axis_cell (
    input  wire logic                             clk,
    input  wire logic signed [pkds_pkg::COORD_W-1:0] coord,
    input  wire logic [pkds_pkg::INVW_W-1:0]      inv_window,
    input  wire logic [pkds_pkg::RADIUS_W-1:0]    radius,
    input  wire pkds_pkg::cell_ctl_t              ctl,
    input  wire pkds_pkg::chain_t                 chain_in,
    output pkds_pkg::chain_t                      chain_out
);
    import pkds_pkg::*;

    logic signed [CPROD_W-1:0] prod_reg;
    logic signed [CPROD_W-1:0] rnd;
    logic signed [SC_W-1:0]    scaled;
    logic signed [SC_W-1:0]    si_reg;
    logic signed [SC_W:0]      diff;
    logic [SC_W:0]             mag;
    logic [ABS_W-1:0]          absd_reg;
    logic                      inside_reg;
    logic [SQ_W-1:0]           sq_reg;

    // round half up: add half an LSB, then arithmetic drop of 16 bits
    assign rnd    = prod_reg + CPROD_W'(32768);
    assign scaled = rnd[CPROD_W-1:16];
    assign diff   = (SC_W+1)'(scaled) - (SC_W+1)'(si_reg);
    assign mag    = diff[SC_W] ? (SC_W+1)'(-diff) : (SC_W+1)'(diff);

    always_ff @(posedge clk)
    begin
        if (ctl.mult)
            prod_reg <= CPROD_W'(coord * $signed({1'b0, inv_window}));
        if (ctl.hold)
            si_reg <= scaled;
        if (ctl.eval)
        begin
            absd_reg   <= mag[ABS_W-1:0];
            inside_reg <= (mag < (SC_W+1)'(radius));
        end
        if (ctl.square)
            sq_reg <= absd_reg * absd_reg;
    end

    assign chain_out.dsq    = chain_in.dsq + DSQ_W'(sq_reg);
    assign chain_out.in_box = chain_in.in_box & inside_reg;
endmodule
`default_nettype wire

// ===== sv/pkds_index_unit.sv =====
// Turns a squared distance into a saturated kernel table index.
`default_nettype none
module pkds_index_unit #(
    parameter int KERNEL_ENTRIES = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [pkds_pkg::DSQ_W-1:0]   dsq,
    input  wire logic [pkds_pkg::MULT_W-1:0]  mult,
    output logic [$clog2(KERNEL_ENTRIES)-1:0] idx
);
    import pkds_pkg::*;
    localparam int KW = $clog2(KERNEL_ENTRIES);

    logic [HL_W-1:0]     hi_reg;
    logic [HL_W-1:0]     lo_reg;
    logic [HL_W:0]       lo_rnd;
    logic [HL_W:0]       total;
    logic [IDXRAW_W-1:0] raw;

    // split multiply: upper and lower 16 bits of the multiplier, read as UQ0.48 (scaled by 2^-48)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg <= HL_W'(dsq * mult[31:16]);
            lo_reg <= HL_W'(dsq * mult[15:0]);
        end
    end

    assign lo_rnd = (HL_W+1)'(lo_reg) + ((HL_W+1)'(1) << 47);
    assign total  = (HL_W+1)'(hi_reg) + (HL_W+1)'(lo_rnd[HL_W:16]);
    assign raw    = total[HL_W:32];
    assign idx    = (raw > IDXRAW_W'(KERNEL_ENTRIES - 1)) ? KW'(KERNEL_ENTRIES - 1)
                                                          : KW'(raw);
endmodule
`default_nettype wire

// ===== sv/pairwise_kernel_density_sum.sv =====
// Top level: point and kernel stores, pair sequencer, axis cell chain, result register.
//
// Usage: requests arrive on req (valid/ready transfer). action selects load kernel
// word, append point, compute or read result. Loads and appends produce nothing;
// compute answers with one result (compute_done 1, zeros); read answers with the
// saturated sum of slot_index. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data), to be written only while idle; the block does not check.
// Loads and appends write on the transfer; a read goes through a registered memory read.
// In a compute over n points each pair walks the three-cell axis chain; a pair inside
// the box then goes through the split index multiplier and one kernel memory read
// before the two sum updates.
// The first n sum store entries are cleared at compute start; entries not covered by
// the last compute read as zero through a tracked count, so reset needs no pass.
// Reset empties the point list and restores configuration defaults.
// Results sit in an output register; loads and appends are still taken while a
// result waits, reads and computes wait until the register frees.
`default_nettype none
`include "pairwise_kernel_density_sum_macros.svh"
module pairwise_kernel_density_sum #(
    parameter int MAX_POINTS     = 1024,
    parameter int KERNEL_ENTRIES = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pkds_in_if.sink                              req,
    pkds_out_if.source                           rsp,
    input  wire logic                            cfg_we,
    input  wire logic [pkds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pkds_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pkds_pkg::*;

    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(KERNEL_ENTRIES);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_READ = 5'd1;
    localparam logic [4:0] ST_CLR  = 5'd2;
    localparam logic [4:0] ST_I0   = 5'd3;
    localparam logic [4:0] ST_I1   = 5'd4;
    localparam logic [4:0] ST_I2   = 5'd5;
    localparam logic [4:0] ST_JRD  = 5'd6;
    localparam logic [4:0] ST_JMUL = 5'd7;
    localparam logic [4:0] ST_JDIF = 5'd8;
    localparam logic [4:0] ST_JSQ  = 5'd9;
    localparam logic [4:0] ST_JSUM = 5'd10;
    localparam logic [4:0] ST_JIDX = 5'd11;
    localparam logic [4:0] ST_JKRD = 5'd12;
    localparam logic [4:0] ST_JPRD = 5'd13;
    localparam logic [4:0] ST_JACC = 5'd14;
    localparam logic [4:0] ST_E0   = 5'd15;
    localparam logic [4:0] ST_E1   = 5'd16;
    localparam logic [4:0] ST_DONE = 5'd17;

    // configuration
    logic [RADIUS_W-1:0] radius_reg;
    logic [MULT_W-1:0]   mult_reg;
    logic [INVW_W-1:0]   invw_reg;

    // control
    logic [4:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] nlast_reg;
    logic          sums_valid_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] clr_reg;
    logic          rd_ok_reg;
    logic [SLOT_W-1:0] rd_slot_reg;

    // payload registers
    logic signed [VALUE_W-1:0] vi_reg;
    logic signed [VALUE_W-1:0] vj_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   sumj_reg;
    logic signed [KWORD_W-1:0] k0_reg;
    logic [DSQ_W-1:0]          dsq_reg;
    logic signed [KPROD_W-1:0] pi_reg;
    logic signed [KPROD_W-1:0] pj_reg;

    // result register
    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic [SLOT_W-1:0]       out_pn_reg;
    logic                    out_done_reg;

    // memories
    logic [PT_W-1:0]           pt_mem [MAX_POINTS];
    logic [PT_W-1:0]           pt_rd_reg;
    logic signed [SUM_W-1:0]   sum_mem [MAX_POINTS];
    logic signed [SUM_W-1:0]   sum_rd_reg;
    logic signed [KWORD_W-1:0] ker_mem [KERNEL_ENTRIES];
    logic signed [KWORD_W-1:0] ker_rd_reg;

    logic              pt_we, pt_re, sum_we, sum_re, ker_we, ker_re;
    logic [PW-1:0]     pt_ra, sum_ra, sum_wa;
    logic [KW-1:0]     ker_ra;
    logic signed [SUM_W-1:0] sum_wd;

    logic          out_free;
    logic          in_xfer;
    logic [CW-1:0] i_inc, j_inc, clr_inc;
    logic [KW-1:0] kidx;
    cell_ctl_t     cell_ctl;
    chain_t        chain [4];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) &&
                       (out_free || req.action == ACT_LOAD || req.action == ACT_APPEND);
    assign in_xfer   = req.valid && req.ready;
    assign i_inc     = i_reg + 1'b1;
    assign j_inc     = j_reg + 1'b1;
    assign clr_inc   = clr_reg + 1'b1;

    // axis cell chain
    assign cell_ctl.mult   = (state_reg == ST_I1) || (state_reg == ST_JMUL);
    assign cell_ctl.hold   = (state_reg == ST_I2);
    assign cell_ctl.eval   = (state_reg == ST_JDIF);
    assign cell_ctl.square = (state_reg == ST_JSQ);
    assign chain[0].in_box = 1'b1;
    assign chain[0].dsq    = '0;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        pkds_axis_cell u_cell (
            .clk        (clk),
            .coord      ($signed(pt_rd_reg[PT_W-1-a*COORD_W -: COORD_W])),
            .inv_window (invw_reg),
            .radius     (radius_reg),
            .ctl        (cell_ctl),
            .chain_in   (chain[a]),
            .chain_out  (chain[a+1])
        );
    end

    pkds_index_unit #(
        .KERNEL_ENTRIES (KERNEL_ENTRIES)
    ) u_index (
        .clk  (clk),
        .en   (state_reg == ST_JIDX),
        .dsq  (dsq_reg),
        .mult (mult_reg),
        .idx  (kidx)
    );

    // memory port steering
    always_comb
    begin
        pt_we  = 1'b0;
        pt_re  = 1'b0;
        pt_ra  = '0;
        sum_we = 1'b0;
        sum_re = 1'b0;
        sum_ra = '0;
        sum_wa = '0;
        sum_wd = '0;
        ker_we = 1'b0;
        ker_re = 1'b0;
        ker_ra = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (req.action == ACT_LOAD)
                        ker_we = (32'(req.slot_index) < KERNEL_ENTRIES);
                    if (req.action == ACT_APPEND)
                        pt_we = (32'(cnt_reg) < MAX_POINTS);
                    if (req.action == ACT_COMPUTE)
                        ker_re = 1'b1;
                    if (req.action == ACT_READ)
                    begin
                        sum_re = 1'b1;
                        sum_ra = PW'(req.slot_index);
                    end
                end
            end
            ST_CLR:
            begin
                sum_we = (clr_reg < n_reg);
                sum_wa = clr_reg[PW-1:0];
            end
            ST_I0:
            begin
                pt_re  = 1'b1;
                pt_ra  = i_reg[PW-1:0];
                sum_re = 1'b1;
                sum_ra = i_reg[PW-1:0];
            end
            ST_JRD:
            begin
                pt_re  = 1'b1;
                pt_ra  = j_reg[PW-1:0];
                sum_re = 1'b1;
                sum_ra = j_reg[PW-1:0];
            end
            ST_JKRD:
            begin
                ker_re = 1'b1;
                ker_ra = kidx;
            end
            ST_JACC:
            begin
                sum_we = 1'b1;
                sum_wa = j_reg[PW-1:0];
                sum_wd = sat_add(sumj_reg, pj_reg);
            end
            ST_E1:
            begin
                sum_we = 1'b1;
                sum_wa = i_reg[PW-1:0];
                sum_wd = sat_add(acc_reg, pi_reg);
            end
            default:
            begin
                pt_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[cnt_reg[PW-1:0]] <= {req.coord_x, req.coord_y, req.coord_z,
                                        req.sample_value};
        if (pt_re)
            pt_rd_reg <= pt_mem[pt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_wa] <= sum_wd;
        if (sum_re)
            sum_rd_reg <= sum_mem[sum_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ker_we)
            ker_mem[KW'(req.slot_index)] <= req.kernel_word;
        if (ker_re)
            ker_rd_reg <= ker_mem[ker_ra];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && req.action == ACT_COMPUTE)
                    state_next = ST_CLR;
                else if (in_xfer && req.action == ACT_READ)
                    state_next = ST_READ;
            end
            ST_READ: state_next = ST_IDLE;
            ST_CLR:
            begin
                if (clr_reg >= n_reg)
                    state_next = (n_reg == '0) ? ST_DONE : ST_I0;
            end
            ST_I0:   state_next = ST_I1;
            ST_I1:   state_next = ST_I2;
            ST_I2:   state_next = (i_inc < n_reg) ? ST_JRD : ST_E0;
            ST_JRD:  state_next = ST_JMUL;
            ST_JMUL: state_next = ST_JDIF;
            ST_JDIF: state_next = ST_JSQ;
            ST_JSQ:  state_next = ST_JSUM;
            ST_JSUM:
            begin
                if (chain[3].in_box)
                    state_next = ST_JIDX;
                else
                    state_next = (j_inc < n_reg) ? ST_JRD : ST_E0;
            end
            ST_JIDX: state_next = ST_JKRD;
            ST_JKRD: state_next = ST_JPRD;
            ST_JPRD: state_next = ST_JACC;
            ST_JACC: state_next = (j_inc < n_reg) ? ST_JRD : ST_E0;
            ST_E0:   state_next = ST_E1;
            ST_E1:   state_next = (i_inc < n_reg) ? ST_I0 : ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            radius_reg     <= '0;
            mult_reg       <= '0;
            invw_reg       <= INVW_RESET;
            cnt_reg        <= '0;
            n_reg          <= '0;
            nlast_reg      <= '0;
            sums_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            clr_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                    CFG_MULT:   mult_reg   <= cfg_data[MULT_W-1:0];
                    CFG_INVW:   invw_reg   <= cfg_data[INVW_W-1:0];
                    default:    radius_reg <= radius_reg;
                endcase
            end
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            if (pt_we)
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == ST_IDLE && in_xfer && req.action == ACT_COMPUTE)
            begin
                n_reg          <= cnt_reg;
                nlast_reg      <= cnt_reg;
                sums_valid_reg <= 1'b1;
                clr_reg        <= '0;
                i_reg          <= '0;
            end
            if (state_reg == ST_IDLE && in_xfer && req.action == ACT_READ)
                rd_ok_reg <= sums_valid_reg && (32'(req.slot_index) < 32'(nlast_reg));
            if (state_reg == ST_CLR && clr_reg < n_reg)
                clr_reg <= clr_inc;
            if (state_reg == ST_I2)
                j_reg <= i_inc;
            if ((state_reg == ST_JSUM && !chain[3].in_box) || state_reg == ST_JACC)
                j_reg <= j_inc;
            if (state_reg == ST_E1)
                i_reg <= i_inc;
            if (state_reg == ST_READ || state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLR)
            k0_reg <= ker_rd_reg;
        if (state_reg == ST_I1)
        begin
            vi_reg  <= $signed(pt_rd_reg[VALUE_W-1:0]);
            acc_reg <= sum_rd_reg;
        end
        if (state_reg == ST_JMUL)
        begin
            vj_reg   <= $signed(pt_rd_reg[VALUE_W-1:0]);
            sumj_reg <= sum_rd_reg;
        end
        if (state_reg == ST_JSUM)
            dsq_reg <= chain[3].dsq;
        if (state_reg == ST_JPRD)
        begin
            pi_reg <= ker_rd_reg * vj_reg;
            pj_reg <= ker_rd_reg * vi_reg;
        end
        if (state_reg == ST_JACC)
            acc_reg <= sat_add(acc_reg, pi_reg);
        if (state_reg == ST_E0)
            pi_reg <= k0_reg * vi_reg;
        if (state_reg == ST_READ)
        begin
            out_sum_reg  <= rd_ok_reg ? sum_rd_reg : '0;
            out_pn_reg   <= rd_slot_reg;
            out_done_reg <= 1'b0;
        end
        if (state_reg == ST_DONE)
        begin
            out_sum_reg  <= '0;
            out_pn_reg   <= '0;
            out_done_reg <= 1'b1;
        end
        if (state_reg == ST_IDLE && in_xfer)
            rd_slot_reg <= req.slot_index;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.density_sum  = out_sum_reg;
    assign rsp.point_number = out_pn_reg;
    assign rsp.compute_done = out_done_reg;

    // a new result never lands on one still waiting
    `PKDS_ASSERT_IMP(a_no_clobber, clk, rst_n, (state_reg == ST_READ || state_reg == ST_DONE), !out_valid_reg, "result register overwritten")
    // pair walk stays inside the loaded set and above the row point
    `PKDS_ASSERT_IMP(a_pair_range, clk, rst_n, state_reg == ST_JRD, (j_reg < n_reg) && (i_reg < j_reg), "pair index out of range")
    // compute ends in a flagged result
    `PKDS_ASSERT_NXT(a_done_flag, clk, rst_n, state_reg == ST_DONE, rsp.valid && rsp.compute_done, "compute result missing")
    // point count never passes capacity
    `PKDS_ASSERT_IMP(a_cnt_cap, clk, rst_n, pt_we, 32'(cnt_reg) < MAX_POINTS, "append past capacity")
endmodule
`default_nettype wire

// ===== tb/pairwise_kernel_density_sum_tb.sv =====
// Self-checking testbench for the pairwise kernel density sum block.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_kernel_density_sum_tb;
    import pkds_pkg::*;

    localparam int NPTS     = 1024;
    localparam int NKERN    = 1024;
    localparam int KLOAD    = 64;    // low kernel words loaded; last entry loaded too
    localparam int IDLE_PCT = 29;
    localparam int LIMIT    = 3000000;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355328;

    // one request transfer
    typedef struct {
        logic [ACTION_W-1:0]       action;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [VALUE_W-1:0] val;
        logic signed [KWORD_W-1:0] kword;
        logic [SLOT_W-1:0]         slot;
    } request_t;

    // one expected response transfer
    typedef struct {
        logic signed [SUM_W-1:0] dsum;
        logic [SLOT_W-1:0]       pnum;
        logic                    done;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pkds_in_if  req ();
    pkds_out_if rsp ();

    pairwise_kernel_density_sum #(
        .MAX_POINTS     (NPTS),
        .KERNEL_ENTRIES (NKERN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // request backlog, filled by the sequence below, drained by the driver
    request_t pending[$];
    answer_t  awaited[$];
    bit       hold_sender = 1'b0;   // sender paused while this is set
    bit       calm = 1'b0;          // no idling on either side
    int       mismatches = 0;
    longint   cycles = 0;

    // shadow of the block: config, point list, kernel table, sums
    logic [RADIUS_W-1:0]  m_radius = '0;
    logic [MULT_W-1:0]    m_mult = '0;
    logic [INVW_W-1:0]    m_invw = INVW_RESET;
    longint               m_coord[NPTS][3];
    longint               m_value[NPTS];
    longint               m_kern[NKERN];
    longint               m_sum[NPTS];
    longint               m_scaled[NPTS][3];
    int                   m_count = 0;

    function automatic longint clamp_sum(longint acc, longint prod);
        longint s;
        s = acc + prod;
        if (s > SUM_HI) return SUM_HI;
        if (s < SUM_LO) return SUM_LO;
        return s;
    endfunction

    // coordinate times inverse window, half rounded up, Q.16
    function automatic longint scaled_coord(longint c);
        longint p;
        p = c * longint'(m_invw);
        return (p + 32768) >>> 16;
    endfunction

    // squared distance to kernel address, saturated at the last entry
    function automatic int kernel_addr(longint dsq);
        logic [127:0] prod;
        prod = (128'(dsq) * 128'(m_mult) + (128'd1 << 47)) >> 48;
        if (prod > 128'(NKERN - 1)) return NKERN - 1;
        return int'(prod);
    endfunction

    // full pair sweep, then the self terms
    task automatic run_density_sweep();
        longint d;
        longint dsq;
        longint k;
        bit     in_box;
        for (int i = 0; i < NPTS; i++) m_sum[i] = 0;
        for (int i = 0; i < m_count; i++)
            for (int a = 0; a < 3; a++) m_scaled[i][a] = scaled_coord(m_coord[i][a]);
        for (int i = 0; i < m_count; i++)
            for (int j = i + 1; j < m_count; j++)
            begin
                dsq = 0;
                in_box = 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    d = m_scaled[j][a] - m_scaled[i][a];
                    if (d < 0) d = -d;
                    if (d >= longint'(m_radius)) in_box = 1'b0;
                    else dsq += d * d;
                end
                if (in_box)
                begin
                    k = m_kern[kernel_addr(dsq)];
                    m_sum[i] = clamp_sum(m_sum[i], k * m_value[j]);
                    m_sum[j] = clamp_sum(m_sum[j], k * m_value[i]);
                end
            end
        for (int i = 0; i < m_count; i++)
            m_sum[i] = clamp_sum(m_sum[i], m_kern[0] * m_value[i]);
    endtask

    // update the shadow for one accepted request, queue its answer
    task automatic predict_request(request_t r);
        answer_t ans;
        case (r.action)
            ACT_LOAD: m_kern[r.slot] = longint'(r.kword);
            ACT_APPEND:
                if (m_count < NPTS)
                begin
                    m_coord[m_count][0] = longint'(r.cx);
                    m_coord[m_count][1] = longint'(r.cy);
                    m_coord[m_count][2] = longint'(r.cz);
                    m_value[m_count] = longint'(r.val);
                    m_count++;
                end
            ACT_COMPUTE:
            begin
                run_density_sweep();
                ans.dsum = '0;
                ans.pnum = '0;
                ans.done = 1'b1;
                awaited.push_back(ans);
            end
            default:
            begin
                ans.dsum = m_sum[r.slot][SUM_W-1:0];
                ans.pnum = r.slot;
                ans.done = 1'b0;
                awaited.push_back(ans);
            end
        endcase
    endtask

    // driver: payload holds until the transfer, gaps at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid        <= 1'b0;
            req.action       <= ACT_LOAD;
            req.coord_x      <= '0;
            req.coord_y      <= '0;
            req.coord_z      <= '0;
            req.sample_value <= '0;
            req.kernel_word  <= '0;
            req.slot_index   <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_request(pending[0]);
                pending.pop_front();
            end
            if (!req.valid || req.ready)
            begin
                if (pending.size() > 0 && !hold_sender
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req.valid        <= 1'b1;
                    req.action       <= pending[0].action;
                    req.coord_x      <= pending[0].cx;
                    req.coord_y      <= pending[0].cy;
                    req.coord_z      <= pending[0].cz;
                    req.sample_value <= pending[0].val;
                    req.kernel_word  <= pending[0].kword;
                    req.slot_index   <= pending[0].slot;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure, compare each response transfer in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if (rsp.valid && rsp.ready)
            begin
                if (awaited.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: sum %0d point %0d done %0b",
                                 rsp.density_sum, rsp.point_number, rsp.compute_done);
                end
                else
                begin
                    if (rsp.density_sum !== awaited[0].dsum
                        || rsp.point_number !== awaited[0].pnum
                        || rsp.compute_done !== awaited[0].done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp sum %0d pt %0d done %0b, got %0d %0d %0b",
                                     awaited[0].dsum, awaited[0].pnum, awaited[0].done,
                                     rsp.density_sum, rsp.point_number, rsp.compute_done);
                    end
                    void'(awaited.pop_front());
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_req(logic [ACTION_W-1:0] act, int x, int y, int z, int v,
                            int kw, int sl);
        request_t r;
        r.action = act;
        r.cx = x[COORD_W-1:0];
        r.cy = y[COORD_W-1:0];
        r.cz = z[COORD_W-1:0];
        r.val = v;
        r.kword = kw[KWORD_W-1:0];
        r.slot = sl[SLOT_W-1:0];
        pending.push_back(r);
    endtask

    // append with random filler in unused fields
    task automatic push_point(int x, int y, int z, int v);
        push_req(ACT_APPEND, x, y, z, v, $urandom, $urandom);
    endtask

    task automatic push_compute();
        push_req(ACT_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic push_read(int sl);
        push_req(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom, sl);
    endtask

    task automatic push_load(int sl, int kw);
        push_req(ACT_LOAD, $urandom, $urandom, $urandom, $urandom, kw, sl);
    endtask

    // let everything drain: backlog empty, every answer back, trailing writes settled
    task automatic drain();
        while (pending.size() > 0 || awaited.size() > 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS: m_radius = data[RADIUS_W-1:0];
            CFG_MULT:   m_mult = data;
            default:    m_invw = data[INVW_W-1:0];
        endcase
    endtask

    // radius plus a multiplier that keeps every in-box pair on the loaded low words
    task automatic set_geometry(int unsigned rad, int unsigned invw);
        logic [79:0] m;
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_INVW, invw);
        if (rad == 0) m = 80'hFFFF_FFFF;
        else m = (80'(KLOAD - 1) << 48) / (80'(3) * 80'(rad) * 80'(rad));
        if (m > 80'hFFFF_FFFF) m = 80'hFFFF_FFFF;
        write_reg(CFG_MULT, m[31:0]);
    endtask

    // a cluster point: usually near the center, now and then anywhere
    function automatic int near(int ctr, int spread);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 262143) - 131072;
        return ctr + $urandom_range(0, 2 * spread) - spread;
    endfunction

    function automatic int any_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    int unsigned rad;
    int unsigned invw;
    int ctr[3];
    int spread;

    initial
    begin
        for (int i = 0; i < NPTS; i++) m_sum[i] = 0;
        for (int i = 0; i < NKERN; i++) m_kern[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Low kernel words and the last entry first; every sweep below stays on them.
        // Extremes at both ends of the table and in the word.
        hold_sender = 1'b1;
        push_load(0, 131071);
        push_load(NKERN - 1, -131072);
        for (int i = 1; i < KLOAD; i++)
            push_load(i, (i % 13 == 0) ? -131072 : $urandom_range(0, 262143) - 131072);
        calm = 1'b1;
        hold_sender = 1'b0;
        drain();
        calm = 1'b0;

        // Reset config: radius zero, so only self terms; empty list computes too.
        push_compute();
        push_read(0);
        push_point(131071, -131072, 0, 32'h7FFF_FFFF);
        push_point(-131072, 131071, 131071, 32'h8000_0000);
        push_compute();
        push_read(0);
        push_read(1);
        push_read(1023);
        drain();

        // Widest box, full-scale window: extreme values saturate the sums.
        set_geometry(131071, 131071);
        push_load(0, -131072);
        push_point(100, 200, -300, 32'h7FFF_FFFF);
        push_point(-100, 0, 300, 32'h7FFF_FFFF);
        push_point(0, 0, 0, 32'h8000_0000);
        push_point(131071, 131071, 131071, 32'h7FFF_FFFF);
        push_compute();
        for (int i = 0; i < 7; i++) push_read(i);
        drain();

        // Zero window and zero multiplier: every point lands on one spot, index 0.
        write_reg(CFG_INVW, 0);
        write_reg(CFG_MULT, 0);
        push_compute();
        for (int i = 0; i < 6; i++) push_read(i);
        drain();
        // Maximum multiplier: the far point pins the last entry, near pairs stay low.
        write_reg(CFG_MULT, 32'hFFFF_FFFF);
        write_reg(CFG_INVW, INVW_RESET);
        push_point(20000, 0, 0, 32'h4000_0000);
        push_compute();
        for (int i = 0; i < 8; i++) push_read(i);
        drain();

        // Random phases: a few loads and appends, one compute, a burst of reads.
        for (int ph = 0; ph < 26; ph++)
        begin
            calm = (ph >= 10 && ph < 14);
            rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                               : $urandom_range(2000, 70000);
            invw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(40000, 90000);
            set_geometry(rad, invw);
            spread = $urandom_range(500, 40000);
            for (int a = 0; a < 3; a++) ctr[a] = $urandom_range(0, 120000) - 60000;
            repeat ($urandom_range(0, 8))
                push_load($urandom_range(0, NKERN - 1), $urandom_range(0, 262143) - 131072);
            repeat ($urandom_range(0, 2))
                push_point(near(ctr[0], spread), near(ctr[1], spread), near(ctr[2], spread),
                           any_value());
            push_compute();
            repeat ($urandom_range(25, 35))
            begin
                if ($urandom_range(0, 7) == 0) push_read($urandom_range(0, NPTS - 1));
                else push_read($urandom_range(0, m_count + 2));
            end
            // stray loads and reads mixed in
            repeat ($urandom_range(0, 3))
                if ($urandom_range(0, 1) == 0) push_read($urandom);
                else push_load($urandom, $urandom);
            drain();
        end
        calm = 1'b0;

        repeat (20) @(negedge clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
